/* sv/llks_pkg.sv */
package llks_pkg;

  // Bytes compared at once: the current byte plus seven earlier bytes.
  localparam int unsigned KW_SPAN  = 8;
  localparam int unsigned HIST_LEN = KW_SPAN - 1;

  localparam int unsigned KW_HIGH_COUNT = 4;
  localparam int unsigned KW_MED_COUNT  = 6;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    SEV_LOW    = 2'd0,
    SEV_MEDIUM = 2'd1,
    SEV_HIGH   = 2'd2
  } severity_t;

  // Window of folded bytes, newest (the current byte) at index 0.
  typedef logic [KW_SPAN-1:0][7:0] win_t;

  // Keywords are right-aligned: the last character sits in the low byte.
  typedef logic [8*KW_SPAN-1:0] kw_text_t;
  typedef logic [3:0] kw_len_t;

  localparam kw_text_t KW_HIGH_TEXT [KW_HIGH_COUNT] = '{
    "panic", "critical", "fatal", "segfault"
  };
  localparam kw_len_t KW_HIGH_LEN [KW_HIGH_COUNT] = '{
    4'd5, 4'd8, 4'd5, 4'd8
  };

  localparam kw_text_t KW_MED_TEXT [KW_MED_COUNT] = '{
    "error", "failed", "failure", "denied", "warning", "warn"
  };
  localparam kw_len_t KW_MED_LEN [KW_MED_COUNT] = '{
    4'd5, 4'd6, 4'd7, 4'd6, 4'd7, 4'd4
  };

  function automatic logic [7:0] fold_byte(input logic [7:0] b);
    logic [7:0] f;
    f = b;
    if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
      f = b + ASCII_CASE_OFFSET;
    end
    return f;
  endfunction

  // True when the keyword ends at the newest byte of the window.
  function automatic logic kw_ends(input win_t win, input kw_text_t text,
                                   input kw_len_t len);
    logic hit;
    hit = 1'b1;
    for (int i = 0; i < KW_SPAN; i++) begin
      if (kw_len_t'(i) < len && win[i] != text[8*i +: 8]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

endpackage

/* sv/log_line_keyword_severity.sv */
// Log line severity classifier. Feed a line one word per cycle on the in_
// channel: in_tdata carries the raw byte, in_tuser says whether that byte is
// valid, and in_tlast marks the final word of the line. Letters are folded to
// lower case and every keyword that ends on a byte is recognized (panic,
// critical, fatal and segfault rank high; error, failed, failure, denied,
// warning and warn rank medium). On the line's final word a single result word
// comes out on the out_ channel with the severity: 2 high, 1 medium, 0 low.
// A word with in_tuser low adds nothing to the line, so such a word with
// in_tlast high closes an empty line (severity 0) or ends a line early.
// Keywords never span two lines. The block takes one word every cycle except
// when held up as told below. The result word is registered: the final word
// waits in the input register, and the keyword compare behind it loads the
// output register once that register is free. Only a stalled result word
// holds up the input, and only when the next word waiting in the input
// register also ends a line.
module log_line_keyword_severity (
  input  logic       clk,
  input  logic       rst_n,

  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,    // [7:0] line_byte
  input  logic       in_tuser,    // [0] byte_present
  input  logic       in_tlast,    // end_of_line

  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata    // [1:0] severity_level, [7:2] zero
);
  import llks_pkg::*;

  // Input register: the folded byte and its flags.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_present_r;
  logic       s1_eol_r;

  // Line state: the seven previous folded bytes, newest at index 0.
  logic [HIST_LEN-1:0][7:0] hist_r, hist_nxt;
  logic                     high_r, high_nxt;
  logic                     med_r, med_nxt;

  // Output register.
  logic      out_valid_r, out_valid_nxt;
  severity_t out_sev_r, out_sev_nxt;

  logic in_fire;
  logic out_free;
  logic s1_fire;
  win_t win;
  logic high_match;
  logic med_match;
  logic high_any;
  logic med_any;

  assign in_fire  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  // A word that does not end a line never needs the output register.
  assign s1_fire  = s1_valid_r && (!s1_eol_r || out_free);
  assign in_tready = !s1_valid_r || s1_fire;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_sev_r};

  // Compare window: the current byte, then the stored history.
  always_comb begin
    win[0] = s1_byte_r;
    for (int i = 0; i < HIST_LEN; i++) begin
      win[i+1] = hist_r[i];
    end
  end

  always_comb begin
    high_match = 1'b0;
    for (int k = 0; k < KW_HIGH_COUNT; k++) begin
      if (kw_ends(win, KW_HIGH_TEXT[k], KW_HIGH_LEN[k])) begin
        high_match = 1'b1;
      end
    end
    med_match = 1'b0;
    for (int k = 0; k < KW_MED_COUNT; k++) begin
      if (kw_ends(win, KW_MED_TEXT[k], KW_MED_LEN[k])) begin
        med_match = 1'b1;
      end
    end
  end

  assign high_any = high_r || (s1_present_r && high_match);
  assign med_any  = med_r  || (s1_present_r && med_match);

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    hist_nxt      = hist_r;
    high_nxt      = high_r;
    med_nxt       = med_r;
    out_valid_nxt = out_valid_r;
    out_sev_nxt   = out_sev_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (s1_fire) begin
      s1_valid_nxt = 1'b0;
      if (s1_present_r) begin
        hist_nxt = {hist_r[HIST_LEN-2:0], s1_byte_r};
      end
      high_nxt = high_any;
      med_nxt  = med_any;
      if (s1_eol_r) begin
        out_valid_nxt = 1'b1;
        if (high_any) begin
          out_sev_nxt = SEV_HIGH;
        end else if (med_any) begin
          out_sev_nxt = SEV_MEDIUM;
        end else begin
          out_sev_nxt = SEV_LOW;
        end
        // The line is over: start the next one from a clean window.
        hist_nxt = '0;
        high_nxt = 1'b0;
        med_nxt  = 1'b0;
      end
    end

    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      hist_r      <= '0;
      high_r      <= 1'b0;
      med_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      hist_r      <= hist_nxt;
      high_r      <= high_nxt;
      med_r       <= med_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    out_sev_r <= out_sev_nxt;
    if (in_fire) begin
      s1_byte_r    <= fold_byte(in_tdata);
      s1_present_r <= in_tuser;
      s1_eol_r     <= in_tlast;
    end
  end

  // A line end wipes the window and both flags.
  a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_eol_r) |=> (!high_r && !med_r && hist_r == '0))
    else $error("line state not cleared after end of line");

  // The input register stalls only behind a blocked result.
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_fire) |-> (s1_eol_r && out_valid_r && !out_tready))
    else $error("input register stalled without a blocked result");

  // A new result appears only after an end-of-line word left the input register.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_fire && s1_eol_r))
    else $error("result word without an end of line");

  // An empty input register always takes a word.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> in_tready)
    else $error("input not ready while input register is empty");

endmodule

/* tb/log_line_keyword_severity_test.sv */
// Self-checking bench for the log line severity classifier.
//
// Lines of bytes go into the in_ channel one word at a time. A monitor sees
// every accepted input word and runs it through a small model of the
// classifier. That model folds capitals, keeps the last seven bytes and looks
// for each keyword that ends on the new byte. At each line end it queues the
// severity that the line should get. The same monitor takes every accepted
// result word and compares it with the oldest queued severity.
//
// The sender works in bursts with random gaps. The receiver stalls on its own
// changing pattern. One phase holds the receiver off for a long stretch while
// the sender keeps offering short lines, so the block fills up and stops
// taking input.
module log_line_keyword_severity_test;
  import llks_pkg::*;

  localparam int HIGH_WORDS    = 4;     // the first entries of keyword_list rank high
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int HANG_LIMIT    = 5000;  // cycles without any handshake before giving up
  localparam int SETTLE_CYCLES = 8;     // margin at the end of the run
  localparam int PRINT_LIMIT   = 40;

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;    // [7:0] line_byte
  logic       in_tuser;    // [0] byte_present
  logic       in_tlast;    // end_of_line
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;   // [1:0] severity_level, [7:2] zero

  // Keywords in one list; the high ones come first.
  string keyword_list [10] = '{"panic", "critical", "fatal", "segfault",
                               "error", "failed", "failure", "denied",
                               "warning", "warn"};

  // State of the line model: the last seven folded bytes, newest in the low
  // byte, and the two flags of the line in progress.
  logic [6:0][7:0] folded_recent = '0;
  bit              line_high     = 1'b0;
  bit              line_medium   = 1'b0;
  severity_t       severity_due [$];

  int error_count  = 0;
  int words_sent   = 0;
  int burst_left   = 0;
  int stall_cycles = 0;
  bit hold_request = 1'b0;

  log_line_keyword_severity DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  // True when the keyword w ends at tail[0], the newest folded byte.
  function automatic bit word_ends_here(input logic [7:0][7:0] tail, input string w);
    bit hit;
    int n;
    hit = 1'b1;
    n = w.len();
    for (int i = 0; i < n; i++) begin
      if (tail[i] != w[n-1-i]) begin
        hit = 1'b0;
      end
    end
    return hit;
  endfunction

  // Line model: one accepted input word. A word without a byte leaves the
  // window and flags alone but can still close the line.
  function automatic void track_line_word(input logic [7:0] b, input logic present,
                                          input logic last);
    logic [7:0]      f;
    logic [7:0][7:0] tail;
    if (present) begin
      f = (b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b;
      tail = {folded_recent, f};
      foreach (keyword_list[k]) begin
        if (word_ends_here(tail, keyword_list[k])) begin
          if (k < HIGH_WORDS) begin
            line_high = 1'b1;
          end else begin
            line_medium = 1'b1;
          end
        end
      end
      folded_recent = {folded_recent[5:0], f};
    end
    if (last) begin
      severity_due.push_back(line_high ? SEV_HIGH : (line_medium ? SEV_MEDIUM : SEV_LOW));
      folded_recent = '0;
      line_high = 1'b0;
      line_medium = 1'b0;
    end
  endfunction

  // Monitor: everything is sampled at the rising edge, in one process, so the
  // order of events inside the time step does not matter. A result can never
  // belong to an input word accepted at the same edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (severity_due.size() == 0) begin
          report_mismatch($sformatf("result word %0h with no line waiting", out_tdata));
        end else begin
          severity_t want;
          want = severity_due.pop_front();
          if (out_tdata[1:0] !== want) begin
            report_mismatch($sformatf("severity %0d, expected %0d",
                                      out_tdata[1:0], want));
          end
          if (out_tdata[7:2] !== 6'd0) begin
            report_mismatch($sformatf("padding bits %0h not zero", out_tdata[7:2]));
          end
        end
      end
      if (in_tvalid && in_tready) begin
        track_line_word(in_tdata, in_tuser, in_tlast);
      end
    end
  end

  // Watchdog: a run that stops moving ends as a failure.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= HANG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Receiver: changes out_tready at the falling edge. It switches between
  // always ready, coin-flip ready, ready one cycle in four and mostly ready,
  // each for a random stretch. On request it holds off for a long stretch,
  // counted here.
  initial begin
    int mode;
    int mode_left;
    int phase;
    mode = 0;
    mode_left = 0;
    phase = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      phase++;
      case (mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (phase % 4 == 0);
        default: out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Sends one word. It starts and returns at a falling edge. Between bursts
  // in_tvalid may drop for a random number of cycles; inside a burst it stays
  // high from word to word.
  task automatic send_word(input logic [7:0] b, input logic present, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= present;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    @(negedge clk);
  endtask

  task automatic go_idle();
    in_tvalid <= 1'b0;
    burst_left = 0;
  endtask

  // The sender stops until every queued severity has come back.
  task automatic pause_until_drained();
    go_idle();
    while (severity_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] random_case(input logic [7:0] b);
    if (b >= "a" && b <= "z" && $urandom_range(0, 1)) begin
      return b - 8'h20;
    end
    return b;
  endfunction

  task automatic send_text(input string s, input logic close_line);
    for (int i = 0; i < s.len(); i++) begin
      send_word(s[i], 1'b1, close_line && (i == s.len() - 1));
    end
  endtask

  // The corner cases, one after the other.
  task automatic test_special_cases();
    // A lone word without a byte closes an empty line: low.
    send_word(8'hA5, 1'b0, 1'b1);
    // A word without a byte inside a keyword is skipped, so the keyword still
    // forms and it ends on the last byte of the line: high.
    send_text("PA", 1'b0);
    send_word(8'h5A, 1'b0, 1'b0);
    send_text("NiC", 1'b1);
    // A line closed by a word without a byte keeps what it found: medium.
    send_text("Warn", 1'b0);
    send_word(8'hFF, 1'b0, 1'b1);
    // A keyword cut by a line end does not count on either side: low twice.
    send_text("fat", 1'b1);
    send_text("al", 1'b1);
    // Bytes just outside the capital range, zero and all ones: low.
    send_word(8'h40, 1'b1, 1'b0);
    send_word(8'h5B, 1'b1, 1'b0);
    send_word(8'h00, 1'b1, 1'b0);
    send_word(8'hFF, 1'b1, 1'b1);
  endtask

  // Well-formed lines made of keywords in random case, keyword prefixes,
  // near misses and noise, with words without a byte mixed in.
  task automatic test_keyword_lines(input int count);
    logic [7:0] line_bytes [$];
    string      w;
    int         stop_at;
    int         cut;
    int         pos;
    bit         close_empty;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      line_bytes.delete();
      repeat ($urandom_range(1, 3)) begin
        w = keyword_list[$urandom_range(0, 9)];
        case ($urandom_range(0, 5))
          0, 1, 2: begin
            for (int i = 0; i < w.len(); i++) line_bytes.push_back(random_case(w[i]));
          end
          3: begin
            cut = $urandom_range(1, w.len() - 1);
            for (int i = 0; i < cut; i++) line_bytes.push_back(random_case(w[i]));
          end
          4: begin
            pos = $urandom_range(0, w.len() - 1);
            for (int i = 0; i < w.len(); i++) begin
              line_bytes.push_back(i == pos ? 8'($urandom_range("a", "z"))
                                            : random_case(w[i]));
            end
          end
          default: begin
            repeat ($urandom_range(1, 4)) begin
              case ($urandom_range(0, 3))
                0, 1: line_bytes.push_back(8'($urandom_range("a", "z")));
                2: line_bytes.push_back(8'($urandom_range("A", "Z")));
                default: line_bytes.push_back(8'($urandom_range(0, 255)));
              endcase
            end
          end
        endcase
      end
      close_empty = ($urandom_range(0, 5) == 0);
      foreach (line_bytes[i]) begin
        if ($urandom_range(0, 11) == 0) begin
          send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end
        send_word(line_bytes[i], 1'b1, !close_empty && (i == line_bytes.size() - 1));
      end
      if (close_empty) begin
        send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end
    end
  endtask

  // Raw noise: any byte, present most of the time, line ends now and then.
  task automatic test_random_bytes(input int count);
    int stop_at;
    stop_at = words_sent + count;
    while (words_sent < stop_at) begin
      send_word(8'($urandom_range(0, 255)), $urandom_range(0, 7) != 0,
                $urandom_range(0, 9) == 0);
    end
  endtask

  // The receiver holds off while the sender keeps offering short lines with
  // no gaps, so results pile up and the block stops taking words.
  task automatic test_output_stall();
    pause_until_drained();
    hold_request = 1'b1;
    burst_left = 1000;
    repeat (40) begin
      if ($urandom_range(0, 1)) begin
        send_text(keyword_list[$urandom_range(0, 9)], 1'b1);
      end else begin
        send_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
      end
    end
    burst_left = 0;
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tuser  = 1'b0;
    in_tlast  = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_special_cases();
    test_keyword_lines(450);
    pause_until_drained();
    test_random_bytes(300);
    test_output_stall();
    test_keyword_lines(250);
    pause_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (severity_due.size() != 0) begin
      report_mismatch($sformatf("%0d line results never arrived", severity_due.size()));
    end
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
